// File: sv/http_request_line_validator_unit_assert.svh
// Assertion macros used by the request line validator engine module.
`ifndef HTTP_REQUEST_LINE_VALIDATOR_UNIT_ASSERT_SVH
`define HTTP_REQUEST_LINE_VALIDATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HRLV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("request line validator check failed");
`define HRLV_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("request line validator implication failed");
`else
`define HRLV_ASSERT(label, prop)
`define HRLV_ASSERT_IMPLIES(label, ante, cons)
`endif

`endif

// File: sv/hrlv_pkg.sv
package hrlv_pkg;

    typedef enum logic [2:0] {
        ST_COMPLETE    = 3'd0,
        ST_INCOMPLETE  = 3'd1,
        ST_INVALID     = 3'd2,
        ST_TOO_LARGE   = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        PH_METHOD  = 5'b00001,
        PH_TARGET  = 5'b00010,
        PH_VERSION = 5'b00100,
        PH_CR      = 5'b01000,
        PH_LF      = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        CFG_MAX_METHOD = 2'd0,
        CFG_MAX_TARGET = 2'd1,
        CFG_MAX_TOTAL  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [13:0] fault_offset;
        logic [7:0]  method_size;
        logic [12:0] target_size;
        logic        minor_version;
        logic [13:0] line_bytes;
    } out_word_t;

    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;
    localparam logic [7:0] CHAR_DOT  = 8'h2e;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] VIS_LO    = 8'h21;
    localparam logic [7:0] VIS_HI    = 8'h7e;

    localparam logic [7:0] VER_PREFIX [5] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f};

    localparam logic [13:0] MAX_METHOD_RESET = 14'd32;
    localparam logic [13:0] MAX_TARGET_RESET = 14'd4096;
    localparam logic [13:0] MAX_TOTAL_RESET  = 14'd8192;

    function automatic logic is_digit(input logic [7:0] b);
        logic r;
        r = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        return r;
    endfunction

    function automatic logic is_tchar(input logic [7:0] b);
        logic r;
        case (b) inside
            [8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39],
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
            8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/hrlv_engine.sv
`include "http_request_line_validator_unit_assert.svh"

module hrlv_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  hrlv_pkg::in_word_t  word,
    input  logic [7:0]          max_method,
    input  logic [12:0]         max_target,
    input  logic [13:0]         cap,
    output logic                emit,
    output hrlv_pkg::out_word_t result
);

    localparam logic [1:0] MINOR_ZERO  = 2'd0;
    localparam logic [1:0] MINOR_ONE   = 2'd1;
    localparam logic [1:0] MINOR_OTHER = 2'd2;

    hrlv_pkg::phase_t phase_reg, phase_next;
    logic [13:0] position_reg, position_next;
    logic [12:0] field_count_reg, field_count_next;
    logic [7:0]  method_len_reg, method_len_next;
    logic [12:0] target_len_reg, target_len_next;
    logic [2:0]  version_index_reg, version_index_next;
    logic [13:0] version_begin_reg, version_begin_next;
    logic        major_is_one_reg, major_is_one_next;
    logic [1:0]  minor_code_reg, minor_code_next;

    logic [7:0]  b;
    logic [13:0] next_pos;
    logic        adv;
    logic        ok;

    always_comb
    begin
        b                  = word.data_byte;
        next_pos           = position_reg + 14'd1;
        adv                = 1'b0;
        ok                 = 1'b0;
        emit               = 1'b0;
        result             = '0;
        result.status      = hrlv_pkg::ST_COMPLETE;
        phase_next         = phase_reg;
        position_next      = position_reg;
        field_count_next   = field_count_reg;
        method_len_next    = method_len_reg;
        target_len_next    = target_len_reg;
        version_index_next = version_index_reg;
        version_begin_next = version_begin_reg;
        major_is_one_next  = major_is_one_reg;
        minor_code_next    = minor_code_reg;

        if (position_reg >= cap)
        begin
            emit                = 1'b1;
            result.status       = hrlv_pkg::ST_TOO_LARGE;
            result.fault_offset = position_reg;
        end
        else
        begin
            unique case (phase_reg)
                hrlv_pkg::PH_METHOD:
                begin
                    if (b == hrlv_pkg::CHAR_SP)
                    begin
                        if (field_count_reg == 13'd0)
                        begin
                            emit                = 1'b1;
                            result.status       = hrlv_pkg::ST_INVALID;
                            result.fault_offset = position_reg;
                        end
                        else
                        begin
                            method_len_next  = field_count_reg[7:0];
                            field_count_next = '0;
                            phase_next       = hrlv_pkg::PH_TARGET;
                            adv              = 1'b1;
                        end
                    end
                    else if (!hrlv_pkg::is_tchar(b))
                    begin
                        emit                = 1'b1;
                        result.status       = hrlv_pkg::ST_INVALID;
                        result.fault_offset = position_reg;
                    end
                    else if (field_count_reg >= {5'd0, max_method})
                    begin
                        emit                = 1'b1;
                        result.status       = hrlv_pkg::ST_TOO_LARGE;
                        result.fault_offset = position_reg;
                    end
                    else
                    begin
                        field_count_next = field_count_reg + 13'd1;
                        adv              = 1'b1;
                    end
                end
                hrlv_pkg::PH_TARGET:
                begin
                    if (b == hrlv_pkg::CHAR_SP)
                    begin
                        if (field_count_reg == 13'd0)
                        begin
                            emit                = 1'b1;
                            result.status       = hrlv_pkg::ST_INVALID;
                            result.fault_offset = position_reg;
                        end
                        else
                        begin
                            target_len_next  = field_count_reg;
                            field_count_next = '0;
                            phase_next       = hrlv_pkg::PH_VERSION;
                            adv              = 1'b1;
                        end
                    end
                    else if ((b < hrlv_pkg::VIS_LO) || (b > hrlv_pkg::VIS_HI))
                    begin
                        emit                = 1'b1;
                        result.status       = hrlv_pkg::ST_INVALID;
                        result.fault_offset = position_reg;
                    end
                    else if (field_count_reg >= max_target)
                    begin
                        emit                = 1'b1;
                        result.status       = hrlv_pkg::ST_TOO_LARGE;
                        result.fault_offset = position_reg;
                    end
                    else
                    begin
                        field_count_next = field_count_reg + 13'd1;
                        adv              = 1'b1;
                    end
                end
                hrlv_pkg::PH_VERSION:
                begin
                    if (version_index_reg == 3'd0)
                    begin
                        version_begin_next = position_reg;
                    end
                    if (version_index_reg < 3'd5)
                    begin
                        ok = (b == hrlv_pkg::VER_PREFIX[version_index_reg]);
                    end
                    else if (version_index_reg == 3'd6)
                    begin
                        ok = (b == hrlv_pkg::CHAR_DOT);
                    end
                    else
                    begin
                        ok = hrlv_pkg::is_digit(b);
                        if (version_index_reg == 3'd5)
                        begin
                            major_is_one_next = (b == hrlv_pkg::CHAR_ONE);
                        end
                        else if (b == hrlv_pkg::CHAR_ZERO)
                        begin
                            minor_code_next = MINOR_ZERO;
                        end
                        else if (b == hrlv_pkg::CHAR_ONE)
                        begin
                            minor_code_next = MINOR_ONE;
                        end
                        else
                        begin
                            minor_code_next = MINOR_OTHER;
                        end
                    end
                    if (!ok)
                    begin
                        emit                = 1'b1;
                        result.status       = hrlv_pkg::ST_INVALID;
                        result.fault_offset = position_reg;
                    end
                    else
                    begin
                        version_index_next = version_index_reg + 3'd1;
                        if (version_index_reg == 3'd7)
                        begin
                            phase_next = hrlv_pkg::PH_CR;
                        end
                        adv = 1'b1;
                    end
                end
                hrlv_pkg::PH_CR:
                begin
                    if (b != hrlv_pkg::CHAR_CR)
                    begin
                        emit                = 1'b1;
                        result.status       = hrlv_pkg::ST_INVALID;
                        result.fault_offset = position_reg;
                    end
                    else
                    begin
                        phase_next = hrlv_pkg::PH_LF;
                        adv        = 1'b1;
                    end
                end
                hrlv_pkg::PH_LF:
                begin
                    emit = 1'b1;
                    if (b != hrlv_pkg::CHAR_LF)
                    begin
                        result.status       = hrlv_pkg::ST_INVALID;
                        result.fault_offset = position_reg;
                    end
                    else if (!major_is_one_reg || (minor_code_reg > MINOR_ONE))
                    begin
                        result.status       = hrlv_pkg::ST_UNSUPPORTED;
                        result.fault_offset = version_begin_reg + 14'd5;
                    end
                    else
                    begin
                        result.status        = hrlv_pkg::ST_COMPLETE;
                        result.method_size   = method_len_reg;
                        result.target_size   = target_len_reg;
                        result.minor_version = minor_code_reg[0];
                        result.line_bytes    = next_pos;
                    end
                end
                default:
                begin
                    emit                = 1'b1;
                    result.status       = hrlv_pkg::ST_INVALID;
                    result.fault_offset = position_reg;
                end
            endcase

            if (adv)
            begin
                if (next_pos >= cap)
                begin
                    emit                = 1'b1;
                    result.status       = hrlv_pkg::ST_TOO_LARGE;
                    result.fault_offset = next_pos;
                end
                else if (word.end_of_data)
                begin
                    emit                = 1'b1;
                    result.status       = hrlv_pkg::ST_INCOMPLETE;
                    result.fault_offset = next_pos;
                end
                else
                begin
                    position_next = next_pos;
                end
            end
        end

        // start a fresh line after any result
        if (emit)
        begin
            phase_next         = hrlv_pkg::PH_METHOD;
            position_next      = '0;
            field_count_next   = '0;
            method_len_next    = '0;
            target_len_next    = '0;
            version_index_next = '0;
            version_begin_next = '0;
            major_is_one_next  = 1'b0;
            minor_code_next    = MINOR_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= hrlv_pkg::PH_METHOD;
            position_reg      <= '0;
            field_count_reg   <= '0;
            method_len_reg    <= '0;
            target_len_reg    <= '0;
            version_index_reg <= '0;
            version_begin_reg <= '0;
            major_is_one_reg  <= 1'b0;
            minor_code_reg    <= MINOR_ZERO;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            position_reg      <= position_next;
            field_count_reg   <= field_count_next;
            method_len_reg    <= method_len_next;
            target_len_reg    <= target_len_next;
            version_index_reg <= version_index_next;
            version_begin_reg <= version_begin_next;
            major_is_one_reg  <= major_is_one_next;
            minor_code_reg    <= minor_code_next;
        end
    end

    `HRLV_ASSERT_IMPLIES(a_complete_only_from_lf, step && emit && (result.status == hrlv_pkg::ST_COMPLETE), phase_reg == hrlv_pkg::PH_LF)
    `HRLV_ASSERT_IMPLIES(a_version_index_idle, phase_reg != hrlv_pkg::PH_VERSION, version_index_reg == 3'd0)
    `HRLV_ASSERT_IMPLIES(a_method_len_clear, phase_reg == hrlv_pkg::PH_METHOD, method_len_reg == 8'd0)

endmodule

// File: sv/hrlv_out_stage.sv
module hrlv_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  hrlv_pkg::out_word_t word,
    input  logic                result_stall,
    output logic                result_valid,
    output hrlv_pkg::out_word_t result_word,
    output logic                free
);

    logic                valid_reg;
    hrlv_pkg::out_word_t word_reg;

    assign free         = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
        end
    end

endmodule

// File: sv/http_request_line_validator_unit.sv
// A byte accepted into the input register is checked there by the engine,
// and a result that it yields is registered in the output stage, which
// raises result_valid. Throughput: one byte per cycle while the output stage
// is free, set by the state update loop. A stalled result holds back the
// engine and the input register. Reset (asynchronous, active low) clears the
// line state and the valid flags and restores the limit registers to 32, 4096 and 8192.
module http_request_line_validator_unit #(
    parameter int unsigned OFFSET_BOUND = 8192
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  hrlv_pkg::in_word_t  byte_word,
    output logic                result_valid,
    input  logic                result_stall,
    output hrlv_pkg::out_word_t result_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [13:0]         cfg_data
);

    logic               in_valid_reg;
    hrlv_pkg::in_word_t in_word_reg;

    logic [7:0]  max_method_reg;
    logic [12:0] max_target_reg;
    logic [13:0] max_total_reg;
    logic [13:0] cap;

    logic                out_free;
    logic                step;
    logic                emit;
    hrlv_pkg::out_word_t step_result;

    assign cfg_ready  = 1'b1;
    assign step       = in_valid_reg && out_free;
    assign byte_stall = in_valid_reg && !out_free;
    assign cap        = (32'(max_total_reg) < OFFSET_BOUND) ? max_total_reg
                                                            : 14'(OFFSET_BOUND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_method_reg <= hrlv_pkg::MAX_METHOD_RESET[7:0];
            max_target_reg <= hrlv_pkg::MAX_TARGET_RESET[12:0];
            max_total_reg  <= hrlv_pkg::MAX_TOTAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hrlv_pkg::CFG_MAX_METHOD: max_method_reg <= cfg_data[7:0];
                hrlv_pkg::CFG_MAX_TARGET: max_target_reg <= cfg_data[12:0];
                hrlv_pkg::CFG_MAX_TOTAL:  max_total_reg  <= cfg_data;
                default:                  max_total_reg  <= max_total_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_word_reg <= byte_word;
        end
    end

    hrlv_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .word       (in_word_reg),
        .max_method (max_method_reg),
        .max_target (max_target_reg),
        .cap        (cap),
        .emit       (emit),
        .result     (step_result)
    );

    hrlv_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step && emit),
        .word         (step_result),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_word  (result_word),
        .free         (out_free)
    );

endmodule
